// ===== src/longest_common_substring_search_top_defines.svh =====
// assertion macros shared by the search block
`ifndef LONGEST_COMMON_SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define LONGEST_COMMON_SUBSTRING_SEARCH_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define LCSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define LCSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define LCSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LCSS_ASSERT(lbl, prop, msg)
`define LCSS_ASSERT_IMP(lbl, ante, cons, msg)
`define LCSS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/lcss_pkg.sv =====
`default_nettype none

package lcss_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2
  } lcss_cmd_e;

  localparam int unsigned PosW  = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 7;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic clear;
    logic append;
    logic text;
    logic last;
  } lcss_ctrl_t;

endpackage

`default_nettype wire

// ===== src/lcss_cell.sv =====
`default_nettype none

module lcss_cell #(
  parameter int unsigned RunW = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcss_pkg::lcss_ctrl_t        ctrl_i,
  input  logic [lcss_pkg::ByteW-1:0]  data_byte_i,
  input  logic [lcss_pkg::PosW-1:0]   text_pos_i,
  input  logic                        left_valid_i,
  input  logic [RunW-1:0]             left_run_i,
  input  logic [RunW-1:0]             left_len_i,
  input  logic [lcss_pkg::PosW-1:0]   left_pos_i,
  output logic                        valid_o,
  output logic [RunW-1:0]             run_o,
  output logic [RunW-1:0]             len_o,
  output logic [lcss_pkg::PosW-1:0]   pos_o
);
  import lcss_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] pat_q;
  logic             load;
  logic             match;
  logic [RunW-1:0]  run_q, run_d, run_new;
  logic [RunW-1:0]  len_q, len_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             take_cand;

  assign load    = ctrl_i.append && !valid_q && left_valid_i;
  assign match   = ctrl_i.text && valid_q && (pat_q == data_byte_i);
  assign run_new = match ? RunW'(left_run_i + 1'b1) : '0;

  // earliest position wins on equal length
  assign take_cand = (run_new > left_len_i) ||
                     ((run_new == left_len_i) && (run_new != '0) && (text_pos_i < left_pos_i));

  always_comb begin
    valid_d = valid_q;
    run_d   = run_q;
    len_d   = take_cand ? run_new : left_len_i;
    pos_d   = take_cand ? text_pos_i : left_pos_i;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
      run_d   = '0;
      len_d   = '0;
      pos_d   = '0;
    end else begin
      if (load) begin
        valid_d = 1'b1;
        run_d   = '0;
      end
      if (ctrl_i.text) begin
        run_d = ctrl_i.last ? '0 : run_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      run_q   <= '0;
      len_q   <= '0;
      pos_q   <= '0;
    end else begin
      valid_q <= valid_d;
      run_q   <= run_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pat_q <= data_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign run_o   = run_q;
  assign len_o   = len_q;
  assign pos_o   = pos_q;

endmodule

`default_nettype wire

// ===== src/longest_common_substring_search_top.sv =====
// text and pattern requests are taken one per cycle while searching
// after the request with the last text byte the input stalls while the drain counter
// runs down from the length of the cell chain and the best-run chain drains; the result
// is registered when the count runs out, and held back while an older result waits
// reset clears pattern length, run row, best run and text position
`default_nettype none
`include "longest_common_substring_search_top_defines.svh"

module longest_common_substring_search_top #(
  parameter int unsigned PATTERN_MAX = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  cmd_i,
  input  logic [lcss_pkg::ByteW-1:0]  data_byte_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [lcss_pkg::LenW-1:0]   match_length_o,
  output logic [lcss_pkg::PosW-1:0]   match_start_o
);
  import lcss_pkg::*;

  localparam int unsigned RunW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CntW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] text_pos_q, text_pos_d;
  logic [RunW-1:0] best_len_q, best_len_d;
  logic [PosW-1:0] best_pos_q, best_pos_d;
  logic            out_valid_q, out_valid_d;
  logic            found_q;
  logic [LenW-1:0] len_q;
  logic [PosW-1:0] start_q;
  logic            accept;
  logic            emit;
  logic            take_tail;
  lcss_ctrl_t      ctrl;

  logic            valid_w [PATTERN_MAX];
  logic [RunW-1:0] run_w   [PATTERN_MAX];
  logic [RunW-1:0] len_w   [PATTERN_MAX];
  logic [PosW-1:0] pos_w   [PATTERN_MAX];

  assign in_ready_o = (state_q == ST_RUN);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ctrl = '0;
    if (accept) begin
      unique case (cmd_i)
        CMD_CLEAR:  ctrl.clear  = 1'b1;
        CMD_APPEND: ctrl.append = 1'b1;
        CMD_TEXT: begin
          ctrl.text = 1'b1;
          ctrl.last = last_i;
        end
        default:    ctrl = '0;
      endcase
    end
  end

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      lcss_cell #(.RunW(RunW)) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .data_byte_i (data_byte_i),
        .text_pos_i  (text_pos_q),
        .left_valid_i(1'b1),
        .left_run_i  ('0),
        .left_len_i  ('0),
        .left_pos_i  ('0),
        .valid_o     (valid_w[k]),
        .run_o       (run_w[k]),
        .len_o       (len_w[k]),
        .pos_o       (pos_w[k])
      );
    end else begin : g_body
      lcss_cell #(.RunW(RunW)) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .data_byte_i (data_byte_i),
        .text_pos_i  (text_pos_q),
        .left_valid_i(valid_w[k-1]),
        .left_run_i  (run_w[k-1]),
        .left_len_i  (len_w[k-1]),
        .left_pos_i  (pos_w[k-1]),
        .valid_o     (valid_w[k]),
        .run_o       (run_w[k]),
        .len_o       (len_w[k]),
        .pos_o       (pos_w[k])
      );
    end
  end

  // fold the chain tail into the running best
  assign take_tail = (len_w[PATTERN_MAX-1] > best_len_q) ||
                     ((len_w[PATTERN_MAX-1] == best_len_q) && (best_len_q != '0) &&
                      (pos_w[PATTERN_MAX-1] < best_pos_q));

  assign emit = (state_q == ST_DRAIN) && (cnt_q == '0) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    text_pos_d  = text_pos_q;
    best_len_d  = take_tail ? len_w[PATTERN_MAX-1] : best_len_q;
    best_pos_d  = take_tail ? pos_w[PATTERN_MAX-1] : best_pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_RUN: begin
        if (ctrl.clear) begin
          text_pos_d = '0;
          best_len_d = '0;
          best_pos_d = '0;
        end else if (ctrl.text) begin
          if (ctrl.last) begin
            text_pos_d = '0;
            state_d    = ST_DRAIN;
            cnt_d      = CntW'(PATTERN_MAX - 1);
          end else if (text_pos_q != '1) begin
            text_pos_d = text_pos_q + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end else if (emit) begin
          out_valid_d = 1'b1;
          state_d     = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      text_pos_q  <= '0;
      best_len_q  <= '0;
      best_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      text_pos_q  <= text_pos_d;
      best_len_q  <= emit ? '0 : best_len_d;
      best_pos_q  <= emit ? '0 : best_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      found_q <= (best_len_d != '0);
      len_q   <= LenW'(best_len_d);
      start_q <= (best_len_d != '0) ? (best_pos_d - PosW'(best_len_d) + 1'b1) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_length_o = len_q;
  assign match_start_o  = start_q;

  `LCSS_ASSERT_NEXT(a_stall_after_last,
    accept && (cmd_i == CMD_TEXT) && last_i, !in_ready_o,
    "input taken while the chain drains")
  `LCSS_ASSERT_IMP(a_empty_result,
    out_valid_o && !found_o, (match_length_o == '0) && (match_start_o == '0),
    "empty result carries a length or start")
  `LCSS_ASSERT_IMP(a_drain_holds,
    (state_q == ST_DRAIN) && (cnt_q != '0), !emit && !in_ready_o,
    "drain ended early")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lcss_pkg::*;

  localparam int unsigned PatternMax = 64;
  localparam int unsigned ItemsTarget = 1650;
  localparam logic [1:0] CmdUndef = 2'd3;

  typedef struct {
    logic [1:0]       cmd;
    logic [ByteW-1:0] data;
    logic             last;
    bit               drain;
  } search_req_t;

  typedef struct {
    logic            found;
    logic [LenW-1:0] length;
    logic [PosW-1:0] start;
  } match_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       cmd_i = CMD_CLEAR;
  logic [ByteW-1:0] data_byte_i = '0;
  logic             last_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             found_o;
  logic [LenW-1:0]  match_length_o;
  logic [PosW-1:0]  match_start_o;

  search_req_t req_q[$];
  match_t      predicted_matches[$];
  search_req_t cur_req;
  int          n_errors = 0;
  int          n_taken = 0;
  int          n_total = 0;
  bit          drain_next = 1'b0;
  logic [ByteW-1:0] alpha[4];

  // search state as the block should hold it
  logic [ByteW-1:0] pat_bytes[PatternMax];
  int               pat_len = 0;
  logic [LenW-1:0]  runs[PatternMax];
  logic [LenW-1:0]  best_len = '0;
  logic [PosW-1:0]  best_end = '0;
  logic [PosW-1:0]  text_pos = '0;

  longest_common_substring_search_top #(
    .PATTERN_MAX(PatternMax)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .data_byte_i   (data_byte_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .match_length_o(match_length_o),
    .match_start_o (match_start_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void clear_text();
    for (int k = 0; k < PatternMax; k++) runs[k] = '0;
    best_len = '0;
    best_end = '0;
    text_pos = '0;
  endfunction

  function automatic void search_step(search_req_t r);
    logic [LenW-1:0] v;
    match_t m;
    case (r.cmd)
      CMD_CLEAR: begin
        pat_len = 0;
        clear_text();
      end
      CMD_APPEND: begin
        if (pat_len < PatternMax) begin
          pat_bytes[pat_len] = r.data;
          runs[pat_len] = '0;
          pat_len++;
        end
      end
      CMD_TEXT: begin
        for (int k = pat_len - 1; k >= 0; k--) begin
          v = '0;
          if (pat_bytes[k] == r.data) begin
            if (k == 0) v = LenW'(1);
            else v = runs[k-1] + 1'b1;
          end
          runs[k] = v;
          if (v > best_len) begin
            best_len = v;
            best_end = text_pos;
          end
        end
        if (text_pos != '1) text_pos++;
        if (r.last) begin
          m.found = (best_len != 0);
          m.length = best_len;
          m.start = m.found ? best_end - PosW'(best_len) + 1'b1 : '0;
          predicted_matches.insert(predicted_matches.size(), m);
          clear_text();
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void push_req(logic [1:0] c, logic [ByteW-1:0] d, logic l);
    search_req_t r;
    r.cmd = c;
    r.data = d;
    r.last = l;
    r.drain = drain_next;
    drain_next = 1'b0;
    req_q.insert(req_q.size(), r);
  endfunction

  function automatic logic [ByteW-1:0] pick_byte();
    if ($urandom_range(0, 99) < 85) return alpha[$urandom_range(0, 3)];
    return ByteW'($urandom);
  endfunction

  // pattern filled to capacity, sometimes past it, then text holding a slice of it
  function automatic void full_pattern_search(bit whole);
    logic [ByteW-1:0] pat[PatternMax];
    int extra, pre, len, off;
    extra = $urandom_range(0, 3);
    push_req(CMD_CLEAR, ByteW'($urandom), 1'($urandom));
    for (int i = 0; i < PatternMax + extra; i++) begin
      if (i < PatternMax) begin
        pat[i] = ByteW'($urandom);
        push_req(CMD_APPEND, pat[i], 1'b0);
      end else begin
        push_req(CMD_APPEND, ByteW'($urandom), 1'($urandom));
      end
    end
    pre = $urandom_range(0, 3);
    for (int i = 0; i < pre; i++) push_req(CMD_TEXT, ByteW'($urandom), 1'b0);
    len = whole ? PatternMax : $urandom_range(1, PatternMax);
    off = $urandom_range(0, PatternMax - len);
    for (int i = 0; i < len; i++) push_req(CMD_TEXT, pat[off+i], i == len - 1);
  endfunction

  function automatic void short_search();
    int plen, tlen;
    for (int i = 0; i < 4; i++) alpha[i] = ByteW'($urandom);
    if ($urandom_range(0, 9) < 8) push_req(CMD_CLEAR, ByteW'($urandom), 1'($urandom));
    plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
    for (int i = 0; i < plen; i++) push_req(CMD_APPEND, pick_byte(), 1'($urandom));
    tlen = $urandom_range(1, 16);
    for (int i = 0; i < tlen; i++) begin
      if ($urandom_range(0, 19) == 0) push_req(CMD_APPEND, pick_byte(), 1'b0);
      push_req(CMD_TEXT, pick_byte(), i == tlen - 1);
    end
  endfunction

  function automatic void noise();
    int n;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 2))
        0: push_req(CmdUndef, ByteW'($urandom), 1'($urandom));
        1: push_req(CMD_APPEND, ByteW'($urandom), 1'b1);
        default: push_req(CMD_TEXT, ByteW'($urandom), 1'b0);
      endcase
    end
  endfunction

  initial begin
    int n_full;
    n_full = 0;
    // empty pattern
    push_req(CMD_TEXT, 8'hff, 1'b1);
    push_req(CMD_APPEND, 8'h00, 1'b0);
    push_req(CMD_APPEND, 8'hff, 1'b0);
    push_req(CMD_APPEND, 8'ha5, 1'b0);
    push_req(CMD_APPEND, 8'h5a, 1'b1);
    push_req(CmdUndef, 8'hff, 1'b1);
    // tie, earliest run wins
    push_req(CMD_TEXT, 8'h00, 1'b0);
    push_req(CMD_TEXT, 8'hff, 1'b0);
    push_req(CMD_TEXT, 8'h11, 1'b0);
    push_req(CMD_TEXT, 8'h00, 1'b0);
    push_req(CMD_TEXT, 8'hff, 1'b1);
    push_req(CMD_TEXT, 8'ha5, 1'b0);
    push_req(CMD_TEXT, 8'h5a, 1'b1);
    push_req(CMD_CLEAR, 8'hff, 1'b1);
    push_req(CMD_TEXT, 8'h00, 1'b1);
    // append in the middle of a search
    push_req(CMD_APPEND, 8'h33, 1'b0);
    push_req(CMD_TEXT, 8'h33, 1'b0);
    push_req(CMD_APPEND, 8'h44, 1'b0);
    push_req(CMD_TEXT, 8'h44, 1'b1);

    while (req_q.size() < ItemsTarget) begin
      if (n_total == 0 && req_q.size() > ItemsTarget / 2) begin
        drain_next = 1'b1;
        n_total = 1;
      end
      if (n_full == 0 || (n_full < 3 && $urandom_range(0, 99) < 4)) begin
        full_pattern_search(n_full == 0);
        n_full++;
      end else if ($urandom_range(0, 99) < 85) begin
        short_search();
      end else begin
        noise();
      end
    end
    push_req(CMD_TEXT, ByteW'($urandom), 1'b1);
    n_total = req_q.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_taken < n_total || predicted_matches.size() != 0) @(posedge clk_i);
    repeat (PatternMax + 20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // request driver
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        search_step(cur_req);
        n_taken++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (req_q.size() != 0 &&
                     !(req_q[0].drain && predicted_matches.size() != 0)) begin
          cur_req = req_q.pop_front();
          cmd_i <= cur_req.cmd;
          data_byte_i <= cur_req.data;
          last_i <= cur_req.last;
          in_valid_i <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else if ($urandom_range(0, 3) == 0) begin
            gap_left = 0;
            burst_left = $urandom_range(20, 80);
          end else begin
            gap_left = $urandom_range(1, 6);
            burst_left = $urandom_range(0, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int n_results = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int phase_left = 0;
  int stall_pct = 0;
  match_t want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (predicted_matches.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result: found %0b length %0d start %0d", $time,
                   found_o, match_length_o, match_start_o);
        end else begin
          want = predicted_matches.pop_front();
          if (found_o !== want.found) begin
            n_errors++;
            $display("%0t: found mismatch: expected %0b, actual %0b", $time,
                     want.found, found_o);
          end
          if (match_length_o !== want.length) begin
            n_errors++;
            $display("%0t: match_length mismatch: expected %0d, actual %0d", $time,
                     want.length, match_length_o);
          end
          if (match_start_o !== want.start) begin
            n_errors++;
            $display("%0t: match_start mismatch: expected %0d, actual %0d", $time,
                     want.start, match_start_o);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (n_results == 12 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 400;
        out_ready_i <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 70;
            default: stall_pct = 95;
          endcase
          phase_left = $urandom_range(20, 100);
        end else begin
          phase_left--;
        end
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

endmodule
